// File: hw/rtl/modified_utf8_encoder_core_assert.svh
// Assertion macros for the modified UTF-8 encoder core.
// Each check samples on aclk and stays quiet while aresetn is low.
`ifndef MODIFIED_UTF8_ENCODER_CORE_ASSERT_SVH
`define MODIFIED_UTF8_ENCODER_CORE_ASSERT_SVH

// Check an implication or plain property on every clock edge.
`define MU8_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that one condition is followed by another on the next edge.
`define MU8_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hw/rtl/mu8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mu8_pkg
// Types and constants shared by the modified UTF-8 encoder modules.
// ----------------------------------------------------------------------------
package mu8_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int UNIT_W      = 16;
    localparam int BUDGET_W    = 18;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_LEN  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATIN1_MODE = 1'b1;

    localparam logic [15:0] BUFFER_LEN_RESET = 16'hFFFF;

    localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
    localparam logic [7:0]  LATIN1_MASK  = 8'hFF;

    localparam logic [2:0] LEAD2_PREFIX = 3'b110;   // 0xC0
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;  // 0xE0
    localparam logic [1:0] CONT_PREFIX  = 2'b10;    // 0x80, payload 0x3F
    localparam logic [7:0] TERM_BYTE    = 8'h00;

    localparam logic [1:0] SIZE_ONE   = 2'd1;
    localparam logic [1:0] SIZE_TWO   = 2'd2;
    localparam logic [1:0] SIZE_THREE = 2'd3;

    // One encoded unit: up to three data bytes, then an optional terminator
    typedef struct packed {
        logic [2:0][7:0] data_bytes;
        logic [1:0]      num_bytes;
        logic            has_term;
        logic            trunc;
    } mu8_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mu8_q_stat_t;

endpackage

// File: hw/rtl/mu8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mu8_front
// Accepts code units, tracks the string budget and encodes each unit that is
// not cut off by truncation into a job for the queue.
// ----------------------------------------------------------------------------
module mu8_front import mu8_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [UNIT_W-1:0]      s_code_unit,
    input  logic                   s_last_unit,
    input  mu8_q_stat_t            q_stat,
    output logic                   push,
    output mu8_job_t               push_job
);

    logic [15:0]                buffer_len_reg;
    logic                       latin1_reg;
    logic signed [BUDGET_W-1:0] budget_reg, budget_next;
    logic                       stopped_reg, stopped_next;
    logic                       in_string_reg, in_string_next;

    logic                       accept;
    logic                       stopped_eff;
    logic [15:0]                unit;
    logic [1:0]                 unit_size;
    logic signed [BUDGET_W-1:0] budget_cur;
    logic signed [BUDGET_W-1:0] budget_sub;
    logic                       trunc_hit;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    assign unit        = latin1_reg ? {8'h00, s_code_unit[7:0] & LATIN1_MASK} : s_code_unit;
    assign stopped_eff = in_string_reg && stopped_reg;
    assign budget_cur  = in_string_reg ? budget_reg
                                       : $signed({{(BUDGET_W-16){1'b0}}, buffer_len_reg});

    always_comb begin
        if ((unit != 16'h0000) && (unit <= ONE_BYTE_MAX)) begin
            unit_size = SIZE_ONE;
        end else if (unit <= TWO_BYTE_MAX) begin
            unit_size = SIZE_TWO;
        end else begin
            unit_size = SIZE_THREE;
        end
    end

    assign budget_sub = budget_cur - $signed({{(BUDGET_W-2){1'b0}}, unit_size});
    assign trunc_hit  = budget_sub[BUDGET_W-1] || (budget_sub == '0);

    // Build the job: bytes in emission order, terminator flagged separately
    always_comb begin
        push_job            = '0;
        push_job.data_bytes = '0;
        if (trunc_hit) begin
            push_job.num_bytes = 2'd0;
            push_job.has_term  = 1'b1;
            push_job.trunc     = 1'b1;
        end else begin
            push_job.num_bytes = unit_size;
            push_job.has_term  = s_last_unit;
            push_job.trunc     = 1'b0;
            unique case (unit_size)
                SIZE_ONE: begin
                    push_job.data_bytes[0] = unit[7:0];
                end
                SIZE_TWO: begin
                    push_job.data_bytes[0] = {LEAD2_PREFIX, unit[10:6]};
                    push_job.data_bytes[1] = {CONT_PREFIX, unit[5:0]};
                end
                SIZE_THREE: begin
                    push_job.data_bytes[0] = {LEAD3_PREFIX, unit[15:12]};
                    push_job.data_bytes[1] = {CONT_PREFIX, unit[11:6]};
                    push_job.data_bytes[2] = {CONT_PREFIX, unit[5:0]};
                end
                default: begin
                    push_job.num_bytes = 2'd0;
                end
            endcase
        end
    end

    // Drop units silently once the string has been cut short
    assign push = accept && !stopped_eff;

    always_comb begin
        budget_next    = budget_reg;
        stopped_next   = stopped_reg;
        in_string_next = in_string_reg;
        if (accept) begin
            budget_next = stopped_eff ? budget_cur : budget_sub;
            if (s_last_unit) begin
                in_string_next = 1'b0;
                stopped_next   = 1'b0;
            end else begin
                in_string_next = 1'b1;
                stopped_next   = stopped_eff || trunc_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_len_reg <= BUFFER_LEN_RESET;
            latin1_reg     <= 1'b0;
            budget_reg     <= '0;
            stopped_reg    <= 1'b0;
            in_string_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BUFFER_LEN:  buffer_len_reg <= cfg_wdata[15:0];
                    CFG_LATIN1_MODE: latin1_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            budget_reg    <= budget_next;
            stopped_reg   <= stopped_next;
            in_string_reg <= in_string_next;
        end
    end

endmodule

// File: hw/rtl/mu8_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mu8_queue
// Short job queue that decouples the encoder front from the byte serialiser.
// ----------------------------------------------------------------------------
module mu8_queue import mu8_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  mu8_job_t    push_job,
    input  logic        pop,
    output mu8_job_t    head_job,
    output mu8_q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mu8_job_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_job     = entries[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/mu8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mu8_back
// Serialises queued jobs into a registered byte stream, one byte per cycle while jobs are queued and m_ready is high.
// ----------------------------------------------------------------------------
module mu8_back import mu8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  mu8_job_t    head_job,
    input  mu8_q_stat_t q_stat,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_terminator,
    output logic        m_truncated
);

    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       term_reg, term_next;
    logic       trunc_reg, trunc_next;
    logic [1:0] idx_reg, idx_next;

    logic       load;
    logic [2:0] elem_total;
    logic       last_elem;
    logic       is_data;

    assign elem_total = {1'b0, head_job.num_bytes} + {2'b00, head_job.has_term};
    assign last_elem  = ({1'b0, idx_reg} + 3'd1) == elem_total;
    assign is_data    = idx_reg < head_job.num_bytes;

    // Refill the output register whenever a job is queued and the register is empty or being drained
    assign load = !q_stat.empty && (!valid_reg || m_ready);
    assign pop  = load && last_elem;

    always_comb begin
        byte_next  = TERM_BYTE;
        term_next  = 1'b0;
        trunc_next = 1'b0;
        if (is_data) begin
            case (idx_reg)
                2'd0:    byte_next = head_job.data_bytes[0];
                2'd1:    byte_next = head_job.data_bytes[1];
                2'd2:    byte_next = head_job.data_bytes[2];
                default: byte_next = TERM_BYTE;
            endcase
        end else begin
            term_next  = 1'b1;
            trunc_next = head_job.trunc;
        end
        idx_next = idx_reg;
        if (load) begin
            idx_next = last_elem ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= byte_next;
            term_reg  <= term_next;
            trunc_reg <= trunc_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_is_terminator = term_reg;
    assign m_truncated     = trunc_reg;

endmodule

// File: hw/rtl/modified_utf8_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modified_utf8_encoder_core
// Modified UTF-8 encoder: one code unit in, encoded bytes and a terminator out.
// ----------------------------------------------------------------------------
// Each code unit yields one to four output bytes (one to three encoded bytes,
// plus the zero terminator on the last unit or on a budget cut), and units
// cut off after truncation yield none. The byte serialiser issues one byte
// per cycle while jobs are queued and the sink is ready. A unit is taken every
// cycle while the job queue has room (QUEUE_DEPTH entries); the job of a unit
// is written into the queue, and its first byte then into the registered
// output. buffer_len is loaded into the budget at the first unit of each
// string, latin1_mode is sampled on every unit.
module modified_utf8_encoder_core import mu8_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [UNIT_W-1:0]      s_code_unit,
    input  logic                   s_last_unit,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_is_terminator,
    output logic                   m_truncated
);

`include "modified_utf8_encoder_core_assert.svh"

    mu8_q_stat_t q_stat;
    mu8_job_t    push_job;
    mu8_job_t    head_job;
    logic        push;
    logic        pop;

    mu8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .s_last_unit (s_last_unit),
        .q_stat      (q_stat),
        .push        (push),
        .push_job    (push_job)
    );

    mu8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    mu8_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_job        (head_job),
        .q_stat          (q_stat),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_terminator (m_is_terminator),
        .m_truncated     (m_truncated)
    );

    `MU8_ASSERT(a_push_not_full, push |-> !q_stat.full, "job pushed into a full queue")
    `MU8_ASSERT(a_trunc_on_term, (m_valid && m_truncated) |-> m_is_terminator, "truncated set off the terminator")
    `MU8_ASSERT(a_term_zero, (m_valid && m_is_terminator) |-> (m_out_byte == TERM_BYTE), "terminator byte not zero")
    `MU8_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, m_valid && $stable(m_out_byte), "output transaction changed while stalled")

endmodule
